/* rtl/core/kce_pkg.sv */
// ----------------------------------------------------------------------------
// kce_pkg - shared types for the k-combination enumerator
// Request and status codes, controller states and the control word that
// the controller broadcasts along the index cell chain.
// ----------------------------------------------------------------------------
package kce_pkg;

   // request codes carried on req_type
   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_START = 2'd1,
      REQ_NEXT  = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_MEMBER    = 3'd0,
      ST_LOADED    = 3'd1,
      ST_STARTED   = 3'd2,
      ST_REJECTED  = 3'd3,
      ST_EXHAUSTED = 3'd4
   } status_type;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CHOOSE_COUNT = 2'd0,
      CSR_SOURCE_COUNT = 2'd1
   } csr_index_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE    = 2'd0,
      S_ROTATE  = 2'd1,
      S_ADVANCE = 2'd2
   } state_type;

   // control word broadcast to every cell
   typedef struct packed {
      logic init;     // load 0..k-1 at start
      logic rotate;   // take the neighbor's index
      logic advance;  // step to the next combination
   } cell_ctrl_type;

endpackage

/* rtl/core/kce_cell.sv */
// ----------------------------------------------------------------------------
// kce_cell - one index cell of the combination chain
// Holds one index of the current combination. Rotates with its neighbor
// while members are read out and takes part in the carry chains that
// step the combination forward.
// ----------------------------------------------------------------------------
module kce_cell #(
   parameter int POS      = 0,
   parameter int IDX_BITS = 6,
   parameter int KC_BITS  = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kce_pkg::cell_ctrl_type ctrl,
   input  logic [KC_BITS-1:0]     active_k,
   input  logic [IDX_BITS-1:0]    base,        // n - k
   input  logic [IDX_BITS-1:0]    rot_in,      // index of the right neighbor
   input  logic                   right_top,   // every cell to the right at top
   input  logic                   follow_in,   // left cell changed, follow it
   input  logic [IDX_BITS-1:0]    left_new,    // new index of the left cell
   output logic [IDX_BITS-1:0]    idx_out,
   output logic                   all_top,     // this and all right cells at top
   output logic                   follow_out,
   output logic [IDX_BITS-1:0]    new_out
);
   import kce_pkg::*;

   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic                active;
   logic                at_top;
   logic                is_pivot;

   // inactive cells count as parked at top
   assign active   = (KC_BITS'(POS) < active_k);
   assign at_top   = !active || (idx_ff == (base + IDX_BITS'(POS)));
   assign is_pivot = active && !at_top && right_top;

   assign all_top    = at_top && right_top;
   assign follow_out = active && (follow_in || is_pivot);

   // successor value of this cell
   always_comb begin
      if (!active) begin
         new_out = idx_ff;
      end else if (follow_in) begin
         new_out = left_new + IDX_BITS'(1);
      end else if (is_pivot) begin
         new_out = idx_ff + IDX_BITS'(1);
      end else begin
         new_out = idx_ff;
      end
   end

   // start loads the cell position; the new k only lands at that same edge,
   // and cells past k are never read out
   always_comb begin
      idx_in = idx_ff;
      if (ctrl.init) begin
         idx_in = IDX_BITS'(POS);
      end else if (ctrl.rotate) begin
         idx_in = rot_in;
      end else if (ctrl.advance) begin
         idx_in = new_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   assign idx_out = idx_ff;

endmodule

/* rtl/core/k_combination_enumerator.sv */
// ----------------------------------------------------------------------------
// k_combination_enumerator - lexicographic k-of-n combination generator
// Stores source words and walks all k-of-n index selections in order.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a clock edge with start high and busy low.
//   req_type selects load (write one source word), start (latch k and n
//   from the CSRs and reset the index list) or next (emit one combination).
//   Results appear on the rsp_ ports for exactly one cycle with rsp_valid;
//   the receiver cannot stall, so every result must be taken as it comes.
//   Load, start and exhausted answers come one cycle after the request and
//   busy stays low, so such requests may follow every cycle.
//   A next request rotates the chain of MAX_K index cells once around; as
//   it turns, the head cell addresses the source memory, and the first k
//   positions yield members, one per cycle, each registered with its word.
//   An advance state then steps the cells to the next combination, and
//   busy stays high through the rotate and advance states.
//   CSR writes (index 0 choose_count, 1 source_count) are always ready.
//   Reset sets k=5, n=7, clears the index cells and marks the run
//   exhausted; source words are undefined until loaded.
// ----------------------------------------------------------------------------
module k_combination_enumerator #(
   parameter int MAX_K      = 7,
   parameter int MAX_SOURCE = 64,
   parameter int WORD_BITS  = 8,
   localparam int KC_BITS   = $clog2(MAX_K + 1),
   localparam int K_BITS    = (MAX_K > 1) ? $clog2(MAX_K) : 1,
   localparam int IDX_BITS  = $clog2(MAX_SOURCE),
   localparam int N_BITS    = $clog2(MAX_SOURCE + 1),
   localparam int CSR_BITS  = (N_BITS > KC_BITS) ? N_BITS : KC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_type,
   input  logic [IDX_BITS-1:0]                 req_load_position,
   input  logic [WORD_BITS-1:0]                req_load_word,
   // result channel
   output logic                                rsp_valid,
   output logic [2:0]                          rsp_status,
   output logic [K_BITS-1:0]                   rsp_slot,
   output logic [IDX_BITS-1:0]                 rsp_source_index,
   output logic [WORD_BITS-1:0]                rsp_member_word,
   output logic                                rsp_last,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kce_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_BITS-1:0]                 csr_wdata
);
   import kce_pkg::*;

   // configuration and run state
   logic [KC_BITS-1:0]   choose_ff;
   logic [N_BITS-1:0]    source_ff;
   logic [KC_BITS-1:0]   act_k_ff, act_k_in;
   logic [N_BITS-1:0]    act_n_ff, act_n_in;
   logic                 exhausted_ff, exhausted_in;
   state_type            state_ff, state_in;
   logic [K_BITS-1:0]    step_ff, step_in;

   // result registers
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic [K_BITS-1:0]    slot_ff, slot_in;
   logic [IDX_BITS-1:0]  index_ff, index_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic                 last_ff, last_in;
   logic                 use_mem_ff, use_mem_in;

   // source memory
   logic [WORD_BITS-1:0] mem [MAX_SOURCE];
   logic [WORD_BITS-1:0] mem_rd_ff;

   // cell chain
   cell_ctrl_type        ctrl;
   logic [IDX_BITS-1:0]  base;
   logic [IDX_BITS-1:0]  cell_idx    [MAX_K];
   logic                 cell_top    [MAX_K];
   logic                 cell_follow [MAX_K];
   logic [IDX_BITS-1:0]  cell_new    [MAX_K];

   logic                 accept;
   req_code_type         req_code;
   logic                 start_ok;
   logic                 emit;
   logic                 step_end;

   assign accept    = start && !busy;
   assign req_code  = req_code_type'(req_type);
   assign csr_ready = 1'b1;
   assign start_ok  = (choose_ff != '0) && (choose_ff <= KC_BITS'(MAX_K))
                      && (N_BITS'(choose_ff) <= source_ff)
                      && (source_ff <= N_BITS'(MAX_SOURCE));
   assign base      = IDX_BITS'(act_n_ff - N_BITS'(act_k_ff));
   assign emit      = (state_ff == S_ROTATE) && (KC_BITS'(step_ff) < act_k_ff);
   assign step_end  = (step_ff == K_BITS'(MAX_K - 1));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         choose_ff <= KC_BITS'(5);
         source_ff <= N_BITS'(7);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CHOOSE_COUNT: choose_ff <= KC_BITS'(csr_wdata);
            CSR_SOURCE_COUNT: source_ff <= N_BITS'(csr_wdata);
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_code == REQ_NEXT) && !exhausted_ff) begin
               state_in = S_ROTATE;
            end
         end
         S_ROTATE: begin
            if (step_end) begin
               state_in = S_ADVANCE;
            end
         end
         S_ADVANCE: state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy         = 1'b1;
      ctrl.init    = 1'b0;
      ctrl.rotate  = 1'b0;
      ctrl.advance = 1'b0;
      case (state_ff)
         S_IDLE: begin
            busy      = 1'b0;
            ctrl.init = accept && (req_code == REQ_START) && start_ok;
         end
         S_ROTATE:  ctrl.rotate  = 1'b1;
         S_ADVANCE: ctrl.advance = !cell_top[0];
         default:   busy = 1'b1;
      endcase
   end

   // run state and result register updates
   always_comb begin
      act_k_in     = act_k_ff;
      act_n_in     = act_n_ff;
      exhausted_in = exhausted_ff;
      step_in      = (state_ff == S_ROTATE) ? step_ff + K_BITS'(1) : '0;
      rsp_valid_in = 1'b0;
      status_in    = ST_MEMBER;
      slot_in      = '0;
      index_in     = '0;
      word_in      = '0;
      last_in      = 1'b1;
      use_mem_in   = 1'b0;
      if (accept) begin
         case (req_code)
            REQ_LOAD: begin
               rsp_valid_in = 1'b1;
               status_in    = ST_LOADED;
               index_in     = req_load_position;
               word_in      = req_load_word;
            end
            REQ_START: begin
               rsp_valid_in = 1'b1;
               if (start_ok) begin
                  status_in    = ST_STARTED;
                  act_k_in     = choose_ff;
                  act_n_in     = source_ff;
                  exhausted_in = 1'b0;
               end else begin
                  status_in = ST_REJECTED;
               end
            end
            REQ_NEXT: begin
               if (exhausted_ff) begin
                  rsp_valid_in = 1'b1;
                  status_in    = ST_EXHAUSTED;
               end
            end
            default: ;
         endcase
      end
      // members come from the head of the rotating chain
      if (emit) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_MEMBER;
         slot_in      = step_ff;
         index_in     = cell_idx[0];
         last_in      = (KC_BITS'(step_ff) == act_k_ff - KC_BITS'(1));
         use_mem_in   = 1'b1;
      end
      if ((state_ff == S_ADVANCE) && cell_top[0]) begin
         exhausted_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         act_k_ff     <= '0;
         act_n_ff     <= '0;
         exhausted_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         act_k_ff     <= act_k_in;
         act_n_ff     <= act_n_in;
         exhausted_ff <= exhausted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      slot_ff    <= slot_in;
      index_ff   <= index_in;
      word_ff    <= word_in;
      last_ff    <= last_in;
      use_mem_ff <= use_mem_in;
   end

   // source memory: one write port, one registered read at the chain head
   always_ff @(posedge clock) begin
      if (accept && (req_code == REQ_LOAD)
          && ((N_BITS)'(req_load_position) < N_BITS'(MAX_SOURCE))) begin
         mem[req_load_position] <= req_load_word;
      end
      mem_rd_ff <= mem[cell_idx[0]];
   end

   // index cell chain
   for (genvar i = 0; i < MAX_K; i++) begin : g_cell
      localparam int NXT = (i + 1) % MAX_K;
      logic                right_top;
      logic                follow_in;
      logic [IDX_BITS-1:0] left_new;
      if (i == MAX_K - 1) begin : g_tail
         assign right_top = 1'b1;
      end else begin : g_mid
         assign right_top = cell_top[i+1];
      end
      if (i == 0) begin : g_head
         assign follow_in = 1'b0;
         assign left_new  = '0;
      end else begin : g_body
         assign follow_in = cell_follow[i-1];
         assign left_new  = cell_new[i-1];
      end
      kce_cell #(
         .POS      (i),
         .IDX_BITS (IDX_BITS),
         .KC_BITS  (KC_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .active_k   (act_k_ff),
         .base       (base),
         .rot_in     (cell_idx[NXT]),
         .right_top  (right_top),
         .follow_in  (follow_in),
         .left_new   (left_new),
         .idx_out    (cell_idx[i]),
         .all_top    (cell_top[i]),
         .follow_out (cell_follow[i]),
         .new_out    (cell_new[i])
      );
   end

   // result ports
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_slot         = slot_ff;
   assign rsp_source_index = index_ff;
   assign rsp_member_word  = use_mem_ff ? mem_rd_ff : word_ff;
   assign rsp_last         = last_ff;

   // checks
   a_advance_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADVANCE) |=> (state_ff == S_IDLE))
      else $error("advance lasted more than one cycle");

   a_rotate_members_only: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == S_ROTATE) && rsp_valid |-> (rsp_status == ST_MEMBER))
      else $error("non-member result during readout");

   a_member_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_MEMBER)
      |-> (N_BITS'(rsp_source_index) < act_n_ff))
      else $error("member index beyond source count");

   a_member_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_MEMBER) && rsp_last
      |-> (KC_BITS'(rsp_slot) == act_k_ff - KC_BITS'(1)))
      else $error("last member marked on the wrong slot");

endmodule

/* test/k_combination_enumerator_tb.sv */
// ----------------------------------------------------------------------------
// k_combination_enumerator_tb - self-checking regression for the enumerator
// Drives load, start and next requests with random idle bursts, rewrites
// k and n between phases, and checks every result against a scoreboard
// that tracks the source store and the index list on its own.
// ----------------------------------------------------------------------------
module k_combination_enumerator_tb;
   import kce_pkg::*;

   localparam int MAX_K         = 7;
   localparam int MAX_SOURCE    = 64;
   localparam int SETTLE_CYCLES = MAX_K + 5;
   localparam int LIMIT_CYCLES  = 100000;
   localparam int RANDOM_ITEMS  = 270;
   localparam int CALM_ITEMS    = 60;

   // one result as it appears on the rsp_ ports
   typedef struct packed {
      status_type  status;
      logic [2:0]  slot;
      logic [5:0]  source_index;
      logic [7:0]  member_word;
      logic        last;
   } enum_result_type;

   // scoreboard: shadow state of the enumerator and the results it owes
   class combination_scoreboard;
      logic [2:0]      choose_reg;
      logic [6:0]      source_reg;
      int              picks [MAX_K];
      int              run_k;
      int              run_n;
      bit              run_done;
      logic [7:0]      words [MAX_SOURCE];
      bit              loaded [MAX_SOURCE];
      enum_result_type pending [$];
      int              fails;
      int              requests;
      int              checked;
      int              members;
      int              exhausted_seen;
      int              rejected_seen;

      function new();
         choose_reg     = 3'd5;
         source_reg     = 7'd7;
         run_k          = 0;
         run_n          = 0;
         run_done       = 1'b1;
         fails          = 0;
         requests       = 0;
         checked        = 0;
         members        = 0;
         exhausted_seen = 0;
         rejected_seen  = 0;
         foreach (picks[i]) picks[i] = 0;
         foreach (words[i]) begin
            words[i]  = 8'd0;
            loaded[i] = 1'b0;
         end
      endfunction

      function void write_config(csr_index_type idx, logic [6:0] value);
         if (idx == CSR_CHOOSE_COUNT) begin
            choose_reg = value[2:0];
         end else if (idx == CSR_SOURCE_COUNT) begin
            source_reg = value;
         end
      endfunction

      // would a start with the current registers be taken
      function bit start_accepts();
         int k;
         int n;
         k = choose_reg;
         n = source_reg;
         return (k >= 1 && k <= MAX_K && k <= n && n <= MAX_SOURCE);
      endfunction

      // lowest store position below upto that was never loaded, or -1
      function int first_unloaded(int upto);
         for (int p = 0; p < upto && p < MAX_SOURCE; p++) begin
            if (!loaded[p]) return p;
         end
         return -1;
      endfunction

      function void push_result(status_type st, int slot, int idx, logic [7:0] word, bit last);
         enum_result_type r;
         r.status       = st;
         r.slot         = 3'(slot);
         r.source_index = 6'(idx);
         r.member_word  = word;
         r.last         = last;
         pending.push_back(r);
      endfunction

      // move to the lexicographically next index list
      function void step_combination();
         int pos;
         pos = -1;
         if (picks[0] == run_n - run_k) begin
            run_done = 1'b1;
            return;
         end
         for (int i = run_k; i > 0; i--) begin
            if (picks[i-1] != run_n - run_k + i - 1) begin
               picks[i-1]++;
               pos = i - 1;
               break;
            end
         end
         if (pos < 0) begin
            run_done = 1'b1;
            return;
         end
         for (int i = pos + 1; i < run_k; i++) picks[i] = picks[i-1] + 1;
      endfunction

      // an accepted request: update shadow state, queue what it owes
      function void note_request(req_code_type code, logic [5:0] pos, logic [7:0] word);
         requests++;
         case (code)
            REQ_LOAD: begin
               words[pos]  = word;
               loaded[pos] = 1'b1;
               push_result(ST_LOADED, 0, pos, word, 1'b1);
            end
            REQ_START: begin
               if (!start_accepts()) begin
                  rejected_seen++;
                  push_result(ST_REJECTED, 0, 0, 8'd0, 1'b1);
               end else begin
                  run_k = choose_reg;
                  run_n = source_reg;
                  for (int i = 0; i < MAX_K; i++) picks[i] = (i < run_k) ? i : 0;
                  run_done = 1'b0;
                  push_result(ST_STARTED, 0, 0, 8'd0, 1'b1);
               end
            end
            REQ_NEXT: begin
               if (run_done || run_k < 1) begin
                  exhausted_seen++;
                  push_result(ST_EXHAUSTED, 0, 0, 8'd0, 1'b1);
               end else begin
                  for (int i = 0; i < run_k; i++) begin
                     push_result(ST_MEMBER, i, picks[i], words[picks[i]], (i + 1 == run_k));
                     members++;
                  end
                  step_combination();
               end
            end
            default: begin
               // unused request code: nothing comes back
            end
         endcase
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $time, msg);
         fails++;
      endtask

      task check_result(logic [2:0] status, logic [2:0] slot, logic [5:0] idx,
                        logic [7:0] word, logic last);
         enum_result_type want;
         if (pending.size() == 0) begin
            report($sformatf("result with nothing pending (status %0d)", status));
            return;
         end
         want = pending.pop_front();
         checked++;
         if (status !== want.status)
            report($sformatf("status got %0d want %0d", status, want.status));
         if (slot !== want.slot)
            report($sformatf("slot got %0d want %0d", slot, want.slot));
         if (idx !== want.source_index)
            report($sformatf("source_index got %0d want %0d", idx, want.source_index));
         if (word !== want.member_word)
            report($sformatf("member_word got %0h want %0h", word, want.member_word));
         if (last !== want.last)
            report($sformatf("last got %0b want %0b", last, want.last));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = REQ_NONE;
   logic [5:0]  req_load_position = 6'd0;
   logic [7:0]  req_load_word = 8'd0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [2:0]  rsp_slot;
   logic [5:0]  rsp_source_index;
   logic [7:0]  rsp_member_word;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_CHOOSE_COUNT;
   logic [6:0]  csr_wdata = 7'd0;

   combination_scoreboard sb;
   bit gaps_on = 1'b1;
   int cycles = 0;
   int settings_used = 0;

   k_combination_enumerator uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_load_position(req_load_position),
      .req_load_word    (req_load_word),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_source_index (rsp_source_index),
      .rsp_member_word  (rsp_member_word),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("k_combination_enumerator regression: fail");
         $finish;
      end
   end

   // every strobed result is checked at the edge that ends its cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && sb != null)
         sb.check_result(rsp_status, rsp_slot, rsp_source_index, rsp_member_word, rsp_last);
   end

   // present one request; start stays high afterwards unless a gap or wait_idle lowers it
   task automatic send_request(req_code_type code, logic [5:0] pos, logic [7:0] word);
      start             <= 1'b1;
      req_type          <= code;
      req_load_position <= pos;
      req_load_word     <= word;
      do @(posedge clock); while (busy);
      sb.note_request(code, pos, word);
   endtask

   task automatic pick_gap();
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // drain all owed results, let a silent request finish, then wait for busy to drop
   task automatic wait_idle();
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic put_csr(csr_index_type idx, logic [6:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_config(idx, value);
   endtask

   // write k and n while the block is idle
   task automatic configure(logic [6:0] k, logic [6:0] n);
      wait_idle();
      settings_used++;
      if (gaps_on && $urandom_range(0, 1) == 0)
         repeat ($urandom_range(1, 11)) @(posedge clock);
      put_csr(CSR_CHOOSE_COUNT, k);
      if (gaps_on && $urandom_range(0, 1) == 0) begin
         csr_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      put_csr(CSR_SOURCE_COUNT, n);
      csr_valid <= 1'b0;
   endtask

   // one random request, biased toward start/next walks; never reads an
   // unloaded store entry
   task automatic random_request(output bit counted);
      int           roll;
      int           hole;
      req_code_type code;
      logic [5:0]   pos;
      logic [7:0]   word;
      roll = $urandom_range(0, 99);
      pos  = 6'($urandom_range(0, 63));
      word = 8'($urandom_range(0, 255));
      if (sb.run_done)
         code = (roll < 55) ? REQ_START : (roll < 75) ? REQ_LOAD :
                (roll < 95) ? REQ_NEXT : REQ_NONE;
      else
         code = (roll < 70) ? REQ_NEXT : (roll < 84) ? REQ_LOAD :
                (roll < 95) ? REQ_START : REQ_NONE;
      if (code == REQ_START && sb.start_accepts()) begin
         hole = sb.first_unloaded(sb.source_reg);
         if (hole >= 0) begin
            code = REQ_LOAD;
            pos  = 6'(hole);
         end
      end
      pick_gap();
      send_request(code, pos, word);
      counted = (code != REQ_NONE);
   endtask

   initial begin
      int         counted_items;
      int         phase_len;
      bit         counted;
      logic [6:0] k_set;
      logic [6:0] n_set;
      counted_items = 0;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: next before any start, unused code, word extremes
      send_request(REQ_NEXT, 6'd0, 8'd0);
      send_request(REQ_NONE, 6'h3f, 8'hff);
      send_request(REQ_LOAD, 6'd0, 8'h00);
      send_request(REQ_LOAD, 6'd1, 8'hff);
      send_request(REQ_LOAD, 6'd2, 8'h5a);
      send_request(REQ_LOAD, 6'd3, 8'ha5);
      send_request(REQ_LOAD, 6'd4, 8'h01);
      send_request(REQ_LOAD, 6'd5, 8'h80);
      send_request(REQ_LOAD, 6'd6, 8'h7e);
      send_request(REQ_LOAD, 6'd63, 8'hff);
      // reset defaults k=5, n=7
      send_request(REQ_START, 6'd0, 8'd0);
      send_request(REQ_NEXT, 6'd0, 8'd0);
      send_request(REQ_NEXT, 6'd0, 8'd0);
      // k = n = MAX_K: a single combination, then exhausted
      configure(7'd7, 7'd7);
      send_request(REQ_START, 6'd0, 8'd0);
      send_request(REQ_NEXT, 6'd0, 8'd0);
      send_request(REQ_NEXT, 6'd0, 8'd0);
      // rejected starts: k zero, k above n, n above the store
      configure(7'd0, 7'd7);
      send_request(REQ_START, 6'd0, 8'd0);
      configure(7'd7, 7'd6);
      send_request(REQ_START, 6'd0, 8'd0);
      configure(7'd3, 7'd65);
      send_request(REQ_START, 6'd0, 8'd0);
      // smallest run
      configure(7'd1, 7'd1);
      send_request(REQ_START, 6'd0, 8'd0);
      send_request(REQ_NEXT, 6'd0, 8'd0);
      send_request(REQ_NEXT, 6'd0, 8'd0);
      // a load during a run, between two next requests
      configure(7'd2, 7'd3);
      send_request(REQ_START, 6'd0, 8'd0);
      send_request(REQ_NEXT, 6'd0, 8'd0);
      send_request(REQ_LOAD, 6'd1, 8'hc3);
      send_request(REQ_NEXT, 6'd0, 8'd0);

      // random phases, each under its own k and n
      while (counted_items < RANDOM_ITEMS) begin
         gaps_on = (counted_items < RANDOM_ITEMS - CALM_ITEMS);
         case ($urandom_range(0, 9))
            0: begin k_set = 7'd1; n_set = 7'd1; end
            1: begin k_set = 7'd7; n_set = 7'd64; end
            2: begin k_set = 7'd1; n_set = 7'd64; end
            3: begin k_set = 7'd7; n_set = 7'd7; end
            4: begin k_set = 7'd0; n_set = 7'($urandom_range(1, 64)); end
            5: begin k_set = 7'd7; n_set = 7'($urandom_range(1, 6)); end
            6: begin
               k_set = 7'($urandom_range(1, 7));
               n_set = 7'($urandom_range(65, 127));
            end
            7: begin k_set = 7'($urandom_range(1, 7)); n_set = 7'd0; end
            default: begin
               k_set = 7'($urandom_range(1, 7));
               n_set = k_set + 7'($urandom_range(0, 4));
            end
         endcase
         configure(k_set, n_set);
         phase_len = $urandom_range(15, 35);
         for (int i = 0; i < phase_len && counted_items < RANDOM_ITEMS; i++) begin
            gaps_on = (counted_items < RANDOM_ITEMS - CALM_ITEMS);
            random_request(counted);
            if (counted) counted_items++;
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d requests under %0d k/n settings, %0d results checked",
               sb.requests, settings_used, sb.checked);
      $display("members %0d, exhausted answers %0d, rejected starts %0d, mismatches %0d",
               sb.members, sb.exhausted_seen, sb.rejected_seen, sb.fails);
      if (sb.fails == 0) begin
         $display("k_combination_enumerator regression: pass");
      end else begin
         $display("k_combination_enumerator regression: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/kce_pkg.sv
rtl/core/kce_cell.sv
rtl/core/k_combination_enumerator.sv
test/k_combination_enumerator_tb.sv
